// ===== rtl/core/ordered_record_table_macros.svh =====
// Assertion macros shared by the ordered record table RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ORDERED_RECORD_TABLE_MACROS_SVH
`define ORDERED_RECORD_TABLE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ORT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ORT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ort_pkg.sv =====
// Types and constants for the ordered record table.
// No dependencies; imported by every module of the block.
package ort_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int KIND_W  = 2;
  localparam int POS_W   = 5;
  localparam int KEY_W   = 37;
  localparam int PAY_W   = 64;
  localparam int STAT_W  = 2;
  localparam int FOUND_W = 4;
  localparam int FILL_W  = 5;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 112;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_MISSING = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic exec;     // apply the operation and load the result register
  } cmd_t;

endpackage

// ===== rtl/core/ort_ctrl.sv =====
// Controller for the ordered record table: two-state sequencer plus
// result valid flag. Depends on ort_pkg.
module ort_ctrl
  import ort_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    s_tready    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        // wait for the result slot to be free or drained this cycle
        if (!out_valid || m_tready) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (cmd.exec) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  assign m_tvalid = out_valid;

endmodule

// ===== rtl/core/ort_datapath.sv =====
// Datapath for the ordered record table: record cells, count, operand
// and result registers. Depends on ort_pkg.
module ort_datapath
  import ort_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [POS_W-1:0]   in_pos,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [PAY_W-1:0]   in_pay,
  output logic [STAT_W-1:0]  res_status,
  output logic [FOUND_W-1:0] res_found,
  output logic [KEY_W-1:0]   res_key,
  output logic [PAY_W-1:0]   res_pay,
  output logic [FILL_W-1:0]  res_fill
);

  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int IW   = $clog2(TABLE_DEPTH);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(TABLE_DEPTH);

  // operand registers
  logic [KIND_W-1:0] op_kind;
  logic [POS_W-1:0]  op_pos;
  logic [KEY_W-1:0]  op_key;
  logic [PAY_W-1:0]  op_pay;

  logic [KEY_W-1:0] key_cells [TABLE_DEPTH];
  logic [PAY_W-1:0] pay_cells [TABLE_DEPTH];
  logic [CW-1:0]    count, count_next;

  logic [CMPW-1:0]        pos_ext, cnt_ext;
  logic                   ins_ok, rem_ok;
  logic [TABLE_DEPTH-1:0] match;
  logic                   hit;
  logic [IW-1:0]          hit_idx;
  logic [IW+FOUND_W-1:0]  found_ext;
  logic [CW+FILL_W-1:0]   fill_ext;
  logic [STAT_W-1:0]      status_c;
  logic [KEY_W-1:0]       rem_key;
  logic [PAY_W-1:0]       rem_pay;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind <= in_kind;
      op_pos  <= in_pos;
      op_key  <= in_key;
      op_pay  <= in_pay;
    end
  end

  assign pos_ext = CMPW'(op_pos);
  assign cnt_ext = CMPW'(count);

  assign ins_ok = (kind_t'(op_kind) == KIND_INSERT) && (cnt_ext < DEPTH_C)
                  && (pos_ext <= cnt_ext);
  assign rem_ok = (kind_t'(op_kind) == KIND_REMOVE) && (pos_ext < cnt_ext);

  // only valid when rem_ok, i.e. the position lies inside the table
  assign rem_key = key_cells[pos_ext[IW-1:0]];
  assign rem_pay = pay_cells[pos_ext[IW-1:0]];

  // parallel key compare over in-use cells, first match wins
  always_comb begin
    hit_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      match[i] = (CMPW'(i) < cnt_ext) && (key_cells[i] == op_key);
      if (match[i]) hit_idx = IW'(i);
    end
    hit = |match;
  end

  always_comb begin
    count_next = count;
    case (kind_t'(op_kind))
      KIND_INSERT: begin
        if (!(cnt_ext < DEPTH_C)) status_c = STAT_FULL;
        else if (!ins_ok)         status_c = STAT_RANGE;
        else begin
          status_c   = STAT_OK;
          count_next = count + 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (!rem_ok) status_c = STAT_RANGE;
        else begin
          status_c   = STAT_OK;
          count_next = count - 1'b1;
        end
      end
      KIND_SEARCH: status_c = hit ? STAT_OK : STAT_MISSING;
      default:     status_c = STAT_OK;
    endcase
  end

  assign found_ext = {{FOUND_W{1'b0}}, hit_idx};
  assign fill_ext  = {{FILL_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.exec) count <= count_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= status_c;
      res_found  <= ((kind_t'(op_kind) == KIND_SEARCH) && hit)
                    ? found_ext[FOUND_W-1:0] : '0;
      res_key    <= rem_ok ? rem_key : '0;
      res_pay    <= rem_ok ? rem_pay : '0;
      res_fill   <= fill_ext[FILL_W-1:0];
    end
  end

  // record cells: shift up on insert, down on remove
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    localparam logic [CMPW-1:0] IDX = CMPW'(g);
    logic [KEY_W-1:0] prev_key, next_key;
    logic [PAY_W-1:0] prev_pay, next_pay;

    if (g > 0) begin : g_prev
      assign prev_key = key_cells[g-1];
      assign prev_pay = pay_cells[g-1];
    end else begin : g_first
      assign prev_key = key_cells[g];
      assign prev_pay = pay_cells[g];
    end

    if (g < TABLE_DEPTH - 1) begin : g_next
      assign next_key = key_cells[g+1];
      assign next_pay = pay_cells[g+1];
    end else begin : g_last
      assign next_key = key_cells[g];
      assign next_pay = pay_cells[g];
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (ins_ok && IDX == pos_ext) begin
          key_cells[g] <= op_key;
          pay_cells[g] <= op_pay;
        end else if (ins_ok && IDX > pos_ext && IDX <= cnt_ext) begin
          key_cells[g] <= prev_key;
          pay_cells[g] <= prev_pay;
        end else if (rem_ok && IDX >= pos_ext && IDX < cnt_ext - 1'b1) begin
          key_cells[g] <= next_key;
          pay_cells[g] <= next_pay;
        end
      end
    end
  end

endmodule

// ===== rtl/core/ordered_record_table.sv =====
// Ordered record table: dense table of key/payload records with insert,
// remove and search. An item is captured into the operand registers, then
// applied in the execute state, once the result slot is free, in which the whole
// cell row shifts and all keys compare in parallel; no new item is taken meanwhile.
// Reset (rst, synchronous): table empties, no result pending; cell contents
// are not cleared. Depends on ort_pkg, ort_ctrl, ort_datapath and the macros.
`include "ordered_record_table_macros.svh"

module ordered_record_table
  import ort_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // entry_index [4:0], entry_key [41:5], entry_payload [105:42], zero [111:106]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // kind [1:0]
  input  logic [KIND_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // found_index [3:0], removed_key [40:4], removed_payload [104:41],
  // fill_count [109:105], zero [111:110]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status [1:0]
  output logic [STAT_W-1:0]     m_tuser
);

  cmd_t cmd;

  logic [FOUND_W-1:0] res_found;
  logic [KEY_W-1:0]   res_key;
  logic [PAY_W-1:0]   res_pay;
  logic [FILL_W-1:0]  res_fill;

  // Sequencer: idle takes an item, exec applies it once the result slot is free.
  ort_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // Cells, count and result register. Unpack the item fields here.
  ort_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_kind    (s_tuser),
    .in_pos     (s_tdata[4:0]),
    .in_key     (s_tdata[41:5]),
    .in_pay     (s_tdata[105:42]),
    .res_status (m_tuser),
    .res_found  (res_found),
    .res_key    (res_key),
    .res_pay    (res_pay),
    .res_fill   (res_fill)
  );

  assign m_tdata = {2'b00, res_fill, res_pay, res_key, res_found};

  // capture and execute are never issued together
  `ORT_ASSERT_NOW(a_cmd_exclusive, cmd.capture, !cmd.exec, "capture and exec together")
  // after an item is taken the block is busy for the execute cycle
  `ORT_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "took item while busy")
  // an execute always produces a pending result
  `ORT_ASSERT_NEXT(a_exec_gives_result, cmd.exec, m_tvalid, "exec without result")
  // reported record count never exceeds the table depth
  `ORT_ASSERT_NOW(a_fill_bound, m_tvalid, m_tdata[109:105] <= TABLE_DEPTH, "fill over depth")

endmodule
